/* hdl/bti_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_pkg
// shared types and constants of the bilinear table interpolator
// ----------------------------------------------------------------------------
package bti_pkg;

    localparam int MAX_POINTS_ONE = 16;
    localparam int MAX_POINTS_TWO = 16;
    localparam int DATA_WIDTH     = 32;
    localparam int GRID_SIZE      = MAX_POINTS_ONE * MAX_POINTS_TWO;
    localparam int IDX1_W         = $clog2(MAX_POINTS_ONE);
    localparam int IDX2_W         = $clog2(MAX_POINTS_TWO);
    localparam int GRID_W         = IDX1_W + IDX2_W;
    localparam int CNT_W          = 5;
    localparam int PROD_W         = 2 * (DATA_WIDTH + 1);
    localparam int DIV_CNT_W      = $clog2(PROD_W + 1);

    typedef enum logic [1:0] {
        CMD_WR_AXIS_ONE = 2'd0,
        CMD_WR_AXIS_TWO = 2'd1,
        CMD_WR_GRID     = 2'd2,
        CMD_INTERP      = 2'd3
    } t_cmd;

    localparam logic CFG_POINTS_ONE = 1'b0;
    localparam logic CFG_POINTS_TWO = 1'b1;

    // request to the serial lerp unit
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] z0;
        logic signed [DATA_WIDTH-1:0] z1;
        logic signed [DATA_WIDTH-1:0] x0;
        logic signed [DATA_WIDTH-1:0] x1;
        logic signed [DATA_WIDTH-1:0] q;
    } t_lerp_req;

endpackage

/* hdl/bti_lerp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_lerp
// one linear step z0 + (dz*dx)/spacing, restoring division one bit a cycle
// ----------------------------------------------------------------------------
module bti_lerp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  bti_pkg::t_lerp_req                i_req,
    output logic                              o_done,
    output logic signed [bti_pkg::DATA_WIDTH-1:0] o_value,
    output logic                              o_err
);
    import bti_pkg::*;

    localparam int EW = DATA_WIDTH + 1;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_OUT} t_state;

    t_state                 r_state;
    logic signed [EW-1:0]   r_dz, r_dx;
    logic [EW-1:0]          r_sp;
    logic signed [DATA_WIDTH-1:0] r_z0;
    logic [PROD_W-1:0]      r_num;
    logic [EW:0]            r_rem;
    logic [DATA_WIDTH-1:0]  r_quo;
    logic                   r_neg;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic                   r_done, r_err;
    logic signed [DATA_WIDTH-1:0] r_value;

    logic signed [EW-1:0] n_sp;
    logic [EW-1:0]        n_ma, n_mb;
    logic [EW:0]          n_rem;

    always_comb begin
        n_sp  = EW'(i_req.x1) - EW'(i_req.x0);
        n_ma  = r_dz[EW-1] ? -r_dz : r_dz;
        n_mb  = r_dx[EW-1] ? -r_dx : r_dx;
        n_rem = {r_rem[EW-1:0], r_num[PROD_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_z0  <= i_req.z0;
                        r_dz  <= EW'(i_req.z1) - EW'(i_req.z0);
                        r_dx  <= EW'(i_req.q) - EW'(i_req.x0);
                        r_sp  <= n_sp;
                        r_err <= 1'b0;
                        if (n_sp <= 0) begin
                            r_err   <= 1'b1;
                            r_value <= i_req.z0;
                            r_done  <= 1'b1;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_num   <= PROD_W'(n_ma) * PROD_W'(n_mb);
                    r_neg   <= r_dz[EW-1] ^ r_dx[EW-1];
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_cnt   <= DIV_CNT_W'(PROD_W);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_num <= r_num << 1;
                    if (n_rem >= {1'b0, r_sp}) begin
                        r_rem <= n_rem - {1'b0, r_sp};
                        r_quo <= {r_quo[DATA_WIDTH-2:0], 1'b1};
                    end else begin
                        r_rem <= n_rem;
                        r_quo <= {r_quo[DATA_WIDTH-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == DIV_CNT_W'(1)) r_state <= S_OUT;
                end
                S_OUT: begin
                    r_value <= r_z0 + (r_neg ? -r_quo : r_quo);
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;
    assign o_err   = r_err;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE) else $error("done outside idle");
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt != '0) else $error("divider count underrun");
    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |=> r_done) else $error("missing done");
endmodule

/* hdl/bilinear_table_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_table_interpolator
// clamped 2-d table lookup with bilinear interpolation, signed q16.16
// ----------------------------------------------------------------------------
// usage
//   a request is taken when i_start is high and o_busy low. commands 0..2
//   write a breakpoint or a grid value into block memories and give no
//   result; the block stays busy while its write state stores the value.
//   command 3 interpolates: the two axes are searched one after the other
//   through the breakpoint memories, each breakpoint read and then compared,
//   then the four corner values are read from the grid memory one by one,
//   and up to three linear steps run on one shared unit, each a multiply
//   and a restoring division. when the result strobe comes is set by the
//   search depth and by how many steps the query needs.
//   the result shows on o_interpolated/o_spacing_error for one cycle with
//   o_valid; the receiver cannot stall.
//   point counts are written on the config channel (i_cfg_valid/o_cfg_ready)
//   only while idle. reset sets both counts to 16; memories are not cleared.
// ----------------------------------------------------------------------------
module bilinear_table_interpolator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic [1:0]                            i_cmd,
    input  logic [7:0]                            i_entry_index,
    input  logic signed [bti_pkg::DATA_WIDTH-1:0] i_write_value,
    input  logic signed [bti_pkg::DATA_WIDTH-1:0] i_query_one,
    input  logic signed [bti_pkg::DATA_WIDTH-1:0] i_query_two,
    output logic                                  o_valid,
    output logic signed [bti_pkg::DATA_WIDTH-1:0] o_interpolated,
    output logic                                  o_spacing_error,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic                                  i_cfg_index,
    input  logic [bti_pkg::CNT_W-1:0]             i_cfg_data
);
    import bti_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_WR, S_S1, S_S2, S_RD, S_RDW, S_PT, S_ROWA, S_ROWB, S_COL, S_DONE
    } t_state;

    // table memories
    logic [DATA_WIDTH-1:0] mem_ax1 [MAX_POINTS_ONE];
    logic [DATA_WIDTH-1:0] mem_ax2 [MAX_POINTS_TWO];
    logic [DATA_WIDTH-1:0] mem_grid [GRID_SIZE];
    logic [DATA_WIDTH-1:0] r_ax1_q, r_ax2_q, r_grid_q;
    logic [IDX1_W-1:0]     n_ax1_a;
    logic [IDX2_W-1:0]     n_ax2_a;
    logic [GRID_W-1:0]     n_grid_a;

    t_state r_state;
    logic [CNT_W-1:0] r_n1, r_n2;
    logic [CNT_W-1:0] r_i, r_j;
    logic [1:0]       r_cmd;
    logic [7:0]       r_idx;
    logic [DATA_WIDTH-1:0] r_wval;
    logic signed [DATA_WIDTH-1:0] r_q1, r_q2;
    logic r_first;  // memory output not yet meaningful
    // corner and breakpoint latches
    logic signed [DATA_WIDTH-1:0] r_g [4];
    logic [1:0] r_rd;
    logic signed [DATA_WIDTH-1:0] r_x1lo, r_x1hi, r_x2lo, r_x2hi;
    logic signed [DATA_WIDTH-1:0] r_za;
    logic r_err, r_lstart, r_valid;
    logic signed [DATA_WIDTH-1:0] r_res;
    t_lerp_req r_req;

    logic l_done, l_err;
    logic signed [DATA_WIDTH-1:0] l_value;

    logic [CNT_W-1:0] n1, n2, r1lo, r1hi, c2lo, c2hi;
    logic in1, in2;

    always_comb begin
        n1 = (r_n1 == '0) ? CNT_W'(1) : (r_n1 > CNT_W'(MAX_POINTS_ONE) ?
             CNT_W'(MAX_POINTS_ONE) : r_n1);
        n2 = (r_n2 == '0) ? CNT_W'(1) : (r_n2 > CNT_W'(MAX_POINTS_TWO) ?
             CNT_W'(MAX_POINTS_TWO) : r_n2);
        in1 = (r_i != '0) && (r_i < n1);
        in2 = (r_j != '0) && (r_j < n2);
        // clamped row/column pair
        r1hi = (r_i == '0) ? '0 : (r_i >= n1 ? n1 - 1'b1 : r_i);
        r1lo = in1 ? r_i - 1'b1 : r1hi;
        c2hi = (r_j == '0) ? '0 : (r_j >= n2 ? n2 - 1'b1 : r_j);
        c2lo = in2 ? r_j - 1'b1 : c2hi;
    end

    // memory addresses
    always_comb begin
        n_ax1_a  = r_i[IDX1_W-1:0];
        n_ax2_a  = r_j[IDX2_W-1:0];
        case (r_rd)
            2'd0:    n_grid_a = {r1lo[IDX1_W-1:0], c2lo[IDX2_W-1:0]};
            2'd1:    n_grid_a = {r1lo[IDX1_W-1:0], c2hi[IDX2_W-1:0]};
            2'd2:    n_grid_a = {r1hi[IDX1_W-1:0], c2lo[IDX2_W-1:0]};
            default: n_grid_a = {r1hi[IDX1_W-1:0], c2hi[IDX2_W-1:0]};
        endcase
        if (r_state == S_PT) begin
            n_ax1_a = in1 ? r1lo[IDX1_W-1:0] : '0;
            n_ax2_a = in2 ? c2lo[IDX2_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WR && r_cmd == CMD_WR_AXIS_ONE && r_idx < 8'(MAX_POINTS_ONE))
            mem_ax1[r_idx[IDX1_W-1:0]] <= r_wval;
        if (r_state == S_WR && r_cmd == CMD_WR_AXIS_TWO && r_idx < 8'(MAX_POINTS_TWO))
            mem_ax2[r_idx[IDX2_W-1:0]] <= r_wval;
        if (r_state == S_WR && r_cmd == CMD_WR_GRID && 9'(r_idx) < 9'(GRID_SIZE))
            mem_grid[r_idx[GRID_W-1:0]] <= r_wval;
        r_ax1_q  <= mem_ax1[n_ax1_a];
        r_ax2_q  <= mem_ax2[n_ax2_a];
        r_grid_q <= mem_grid[n_grid_a];
    end

    bti_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_lstart),
        .i_req   (r_req),
        .o_done  (l_done),
        .o_value (l_value),
        .o_err   (l_err)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_n1     <= CNT_W'(16);
            r_n2     <= CNT_W'(16);
            r_valid  <= 1'b0;
            r_lstart <= 1'b0;
        end else begin
            r_valid  <= 1'b0;
            r_lstart <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_POINTS_ONE) r_n1 <= i_cfg_data;
                else r_n2 <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd <= i_cmd; r_idx <= i_entry_index; r_wval <= i_write_value;
                        r_q1 <= i_query_one; r_q2 <= i_query_two;
                        r_i <= '0; r_j <= '0; r_first <= 1'b1; r_err <= 1'b0;
                        r_state <= (i_cmd == CMD_INTERP) ? S_S1 : S_WR;
                    end
                end
                S_WR: r_state <= S_IDLE;
                // axis-one search: memory data of entry r_i is registered and appears in the next cycle
                S_S1: begin
                    if (r_first) r_first <= 1'b0;
                    else if (r_i < n1 && r_q1 > $signed(r_ax1_q)) begin
                        r_i <= r_i + 1'b1; r_first <= 1'b1;
                    end else begin
                        r_state <= S_S2; r_first <= 1'b1;
                    end
                end
                S_S2: begin
                    if (r_first) r_first <= 1'b0;
                    else if (r_j < n2 && r_q2 > $signed(r_ax2_q)) begin
                        r_j <= r_j + 1'b1; r_first <= 1'b1;
                    end else begin
                        r_state <= S_PT; r_rd <= 2'd0;
                    end
                end
                // read lower breakpoints (addr set this cycle), upper follow
                S_PT: r_state <= S_RD;
                S_RD: begin
                    if (r_rd == 2'd0) begin
                        r_x1lo <= r_ax1_q; r_x2lo <= r_ax2_q;
                    end
                    r_i <= r_i; r_state <= S_RDW;
                end
                S_RDW: begin
                    r_g[r_rd] <= r_grid_q;
                    if (r_rd == 2'd3) begin
                        r_state <= S_ROWA;
                        r_req <= '{z0: r_g[0], z1: r_g[1], x0: r_x2lo, x1: r_x2hi, q: r_q2};
                        r_lstart <= in2;
                    end else begin
                        r_rd <= r_rd + 1'b1; r_state <= S_RD;
                    end
                end
                S_ROWA: begin
                    if (!in2) begin
                        r_za <= r_g[0];
                        r_state <= in1 ? S_ROWB : S_DONE;
                        r_req <= '{z0: r_g[2], z1: r_g[3], x0: r_x2lo, x1: r_x2hi, q: r_q2};
                        r_lstart <= in2 && in1;
                        if (!in1) r_res <= r_g[0];
                    end else if (l_done) begin
                        r_za <= l_value; r_err <= r_err | l_err;
                        r_state <= in1 ? S_ROWB : S_DONE;
                        r_req <= '{z0: r_g[2], z1: r_g[3], x0: r_x2lo, x1: r_x2hi, q: r_q2};
                        r_lstart <= in1;
                        if (!in1) r_res <= l_value;
                    end
                end
                S_ROWB: begin
                    if (!in2) begin
                        r_state <= S_COL;
                        r_req <= '{z0: r_za, z1: r_g[2], x0: r_x1lo, x1: r_x1hi, q: r_q1};
                        r_lstart <= 1'b1;
                    end else if (l_done) begin
                        r_err <= r_err | l_err; r_state <= S_COL;
                        r_req <= '{z0: r_za, z1: l_value, x0: r_x1lo, x1: r_x1hi, q: r_q1};
                        r_lstart <= 1'b1;
                    end
                end
                S_COL: begin
                    if (l_done) begin
                        r_res <= l_value; r_err <= r_err | l_err; r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_valid <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // upper breakpoints: the hi rows (lower+1 inside the axis), read in S_RDW
    always_ff @(posedge i_clk) begin
        if (r_state == S_RDW && r_rd == 2'd0) begin
            r_x1hi <= mem_ax1[in1 ? r1hi[IDX1_W-1:0] : '0];
            r_x2hi <= mem_ax2[in2 ? c2hi[IDX2_W-1:0] : '0];
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_cfg_ready     = (r_state == S_IDLE) && !i_start;
    assign o_valid         = r_valid;
    assign o_interpolated  = r_res;
    assign o_spacing_error = r_err;

    a_valid_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid) else $error("result repeated");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_valid && r_state == S_IDLE) else $error("lost result");
    a_wr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR |=> !r_valid) else $error("write gave result");
endmodule
